[rtl/csgs_pkg.sv]
package csgs_pkg;

  // Grid geometry
  localparam int HALF_SPAN  = 31;
  localparam int SIDE       = 63;
  localparam int CELL_COUNT = SIDE * SIDE;
  localparam int IDX_W      = $clog2(CELL_COUNT);

  // Raw index (x + HALF_SPAN) * SIDE + (HALF_SPAN - y) before the range check
  localparam int RAW_MAX    = (2 * HALF_SPAN) * SIDE + 2 * HALF_SPAN;
  localparam int RAW_W      = $clog2(RAW_MAX + 1);

  localparam logic [7:0] CEILING_RST = 8'd255;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_CHANGE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

endpackage

[rtl/centered_grid_saturating_store.sv]
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// input     | in_valid / in_ready   | action, x_coord, y_coord, operand
// result    | out_valid / out_ready | cell_value, in_bounds
// config    | cfg_wr_en             | cfg_wr_data (saturation ceiling)
//
// One beat in and one beat out per cycle while the result is taken; a beat
// passes the input register, the cell read register and the result register.
// The per-cycle rate is set by the single registered read port of the cell
// memory; a one-entry write-forwarding register covers back-to-back updates.
// After reset a clearing pass writes zero to every cell, one per cycle, all
// SIDE*SIDE (3969) of them; in_ready stays low meanwhile, config is still taken.
// A stalled result holds the whole pipe, but an empty input register still
// takes a beat while the result waits.
module centered_grid_saturating_store (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  // input beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csgs_pkg::action_t     action,
  input  logic signed [7:0]     x_coord,
  input  logic signed [7:0]     y_coord,
  input  logic signed [8:0]     operand,
  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            cell_value,
  output logic                  in_bounds
);
  import csgs_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [7:0] ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling <= CEILING_RST;
    end else if (cfg_wr_en) begin
      ceiling <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IDX_W'(CELL_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipe advances when the result register frees
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_accept;
  logic v1;
  logic v2;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !clearing && (advance || !v1);
  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 1: input register, bounds check and cell index
  // ---------------------------------------------------------------------------
  action_t           s1_action;
  logic signed [7:0] s1_x;
  logic signed [7:0] s1_y;
  logic signed [8:0] s1_operand;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action  <= action;
      s1_x       <= x_coord;
      s1_y       <= y_coord;
      s1_operand <= operand;
    end
  end

  logic signed [9:0] x_ext;
  logic signed [9:0] y_ext;
  logic signed [9:0] off_x;
  logic signed [9:0] off_y;
  logic              coord_ok;
  logic [RAW_W-1:0]  raw_idx;
  logic              s1_inb;
  logic [IDX_W-1:0]  s1_idx;

  always_comb begin
    x_ext    = {{2{s1_x[7]}}, s1_x};
    y_ext    = {{2{s1_y[7]}}, s1_y};
    off_x    = x_ext + 10'(HALF_SPAN);
    off_y    = 10'(HALF_SPAN) - y_ext;
    // both offsets land in 0..2*HALF_SPAN exactly when |x| and |y| fit
    coord_ok = (off_x >= 10'sd0) && (off_x <= 10'(2 * HALF_SPAN)) &&
               (off_y >= 10'sd0) && (off_y <= 10'(2 * HALF_SPAN));
    raw_idx  = RAW_W'(off_x[7:0]) * RAW_W'(SIDE) + RAW_W'(off_y[7:0]);
    s1_inb   = coord_ok && (raw_idx < RAW_W'(CELL_COUNT));
    s1_idx   = s1_inb ? raw_idx[IDX_W-1:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cell read data, forwarding and update
  // ---------------------------------------------------------------------------
  action_t           s2_action;
  logic signed [8:0] s2_operand;
  logic              s2_inb;
  logic [IDX_W-1:0]  s2_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_accept) begin
        v1 <= 1'b1;
      end else if (advance) begin
        v1 <= 1'b0;
      end
      if (advance) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_action  <= s1_action;
      s2_operand <= s1_operand;
      s2_inb     <= s1_inb;
      s2_idx     <= s1_idx;
    end
  end

  // Cell memory: one write port, one registered read port
  logic [7:0]       mem [CELL_COUNT];
  logic [7:0]       mem_q;
  logic             item_we;
  logic [7:0]       new_val;

  // Last item write, for the item read while that write was in flight
  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_idx;
  logic [7:0]       fwd_data;

  always_ff @(posedge clk) begin
    if (advance) begin
      mem_q <= mem[s1_idx];
    end
    if (clearing) begin
      mem[clr_idx] <= 8'd0;
    end else if (item_we) begin
      mem[s2_idx] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (item_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      fwd_idx  <= s2_idx;
      fwd_data <= new_val;
    end
  end

  logic [7:0]        cur_val;
  logic signed [9:0] sum;
  logic              writes;

  always_comb begin
    cur_val = (fwd_valid && (fwd_idx == s2_idx)) ? fwd_data : mem_q;
    sum     = $signed({2'b00, cur_val}) + $signed({s2_operand[8], s2_operand});
    new_val = cur_val;
    writes  = 1'b0;
    case (s2_action)
      ACT_SET: begin
        new_val = s2_operand[7:0];
        writes  = 1'b1;
      end
      ACT_CHANGE: begin
        // clamp low to zero, high to the configured ceiling
        if (sum < 10'sd0) begin
          new_val = 8'd0;
        end else if (sum > $signed({2'b00, ceiling})) begin
          new_val = ceiling;
        end else begin
          new_val = sum[7:0];
        end
        writes = 1'b1;
      end
      default: begin
        // read, and the unused code, leave the cell as it is
        new_val = cur_val;
        writes  = 1'b0;
      end
    endcase
  end

  assign item_we = advance && v2 && s2_inb && writes;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_value <= s2_inb ? new_val : 8'd0;
      in_bounds  <= s2_inb;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !clearing)
    else $error("input beat taken during clearing pass");

  a_no_item_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    item_we |-> !clearing && !v1 || !clearing)
    else $error("item write collides with clearing pass");

  a_out_of_bounds_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_bounds |-> cell_value == 8'd0)
    else $error("out-of-bounds result carries a nonzero value");

  a_change_below_ceiling: assert property (@(posedge clk) disable iff (rst)
    item_we && (s2_action == ACT_CHANGE) |-> new_val <= ceiling)
    else $error("saturating change exceeds the ceiling");

  a_forward_matches_write: assert property (@(posedge clk) disable iff (rst)
    item_we |=> fwd_valid && (fwd_idx == $past(s2_idx)) && (fwd_data == $past(new_val)))
    else $error("forwarding register lost the last write");

endmodule

[tb/sv/centered_grid_saturating_store_test.sv]
module centered_grid_saturating_store_test;
  import csgs_pkg::*;

  // Spare action code: the block must treat it as a read.
  localparam action_t ACT_SPARE = action_t'(2'd3);

  // Cycles from an input beat to its result beat, plus some slack.
  localparam int PIPE_DEPTH = 6;

  typedef struct packed {
    logic [7:0] value;
    logic       hit;
  } cell_beat_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [7:0]        cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  action_t           action;
  logic signed [7:0] x_coord;
  logic signed [7:0] y_coord;
  logic signed [8:0] operand;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        cell_value;
  logic              in_bounds;

  // Shadow copy of the grid and the ceiling register.
  logic [7:0]        grid_mem [0:CELL_COUNT-1];
  logic [7:0]        ceiling;
  // Cell results still owed by the block, oldest first.
  cell_beat_t        pending_cells [$];
  int                mismatch_count;
  // Random idling on both channels while set.
  bit                idle_on;
  // Last addressed coordinate, reused to hit the same cell back to back.
  int                last_x;
  int                last_y;

  centered_grid_saturating_store u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .operand     (operand),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cell_value  (cell_value),
    .in_bounds   (in_bounds)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Apply one beat to the shadow grid and return the cell beat it must produce.
  function automatic cell_beat_t predict_cell(action_t act, logic signed [7:0] x,
                                              logic signed [7:0] y,
                                              logic signed [8:0] opnd);
    cell_beat_t res;
    int ix;
    int iy;
    int idx;
    int sum;
    int delta;
    res = '{value: 8'd0, hit: 1'b0};
    ix = x;
    iy = y;
    if (ix > HALF_SPAN || ix < -HALF_SPAN || iy > HALF_SPAN || iy < -HALF_SPAN)
      return res;
    idx = (ix + HALF_SPAN) * SIDE + (HALF_SPAN - iy);
    // Guard only: with SIDE = 2*HALF_SPAN+1 no in-span index lies outside the store.
    if (idx < 0 || idx >= CELL_COUNT)
      return res;
    case (act)
      ACT_SET: begin
        // Store the low byte; the ceiling does not limit a set.
        grid_mem[idx] = opnd[7:0];
      end
      ACT_CHANGE: begin
        delta = opnd;
        sum = grid_mem[idx];
        sum = sum + delta;
        if (sum < 0)
          sum = 0;
        // Clamp even when the cell already sat above the ceiling.
        if (sum > int'(ceiling))
          sum = ceiling;
        grid_mem[idx] = sum[7:0];
      end
      default: begin
        // Read and the spare code leave the cell alone.
      end
    endcase
    res.value = grid_mem[idx];
    res.hit   = 1'b1;
    return res;
  endfunction

  // Send one beat. Enter and leave at a falling edge; valid stays high on
  // exit, so the caller must send again or drop it in the same step.
  task automatic send_beat(action_t act, int x, int y, int opnd);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    x_coord  <= x[7:0];
    y_coord  <= y[7:0];
    operand  <= opnd[8:0];
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    // Beat taken at this edge: advance the shadow grid in acceptance order.
    pending_cells.push_back(predict_cell(act, x[7:0], y[7:0], opnd[8:0]));
    last_x = x;
    last_y = y;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic settle_pipe();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0)
      @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  // Write the ceiling; call only with the pipe empty, at a falling edge.
  task automatic write_ceiling(logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    ceiling = value;
  endtask

  // The four corners and the center must read zero after the clearing pass;
  // one corner is read with the spare code.
  task automatic test_cleared_after_reset();
    send_beat(ACT_READ, -HALF_SPAN, HALF_SPAN, 0);
    send_beat(ACT_READ, HALF_SPAN, -HALF_SPAN, 0);
    send_beat(ACT_READ, 0, 0, 0);
    send_beat(ACT_READ, HALF_SPAN, HALF_SPAN, 0);
    send_beat(ACT_SPARE, -HALF_SPAN, -HALF_SPAN, 0);
  endtask

  // Field extremes: full-width operands, saturation at both ends, the four
  // corner cells and coordinates just past them and at the type limits.
  task automatic test_field_edges();
    send_beat(ACT_SET, 0, 0, 255);
    send_beat(ACT_CHANGE, 0, 0, 127);       // saturate at the top
    send_beat(ACT_CHANGE, 0, 0, -128);
    send_beat(ACT_CHANGE, 0, 0, -256);      // 9-bit delta, clamp to zero
    send_beat(ACT_CHANGE, 0, 0, 255);       // 9-bit delta upward
    send_beat(ACT_SET, -HALF_SPAN, HALF_SPAN, -1);   // low byte of a negative
    send_beat(ACT_SET, HALF_SPAN, -HALF_SPAN, -128);
    send_beat(ACT_SET, HALF_SPAN, HALF_SPAN, -256);
    send_beat(ACT_SET, -HALF_SPAN, -HALF_SPAN, 170);
    send_beat(ACT_SET, HALF_SPAN + 1, 0, 99);        // just outside
    send_beat(ACT_CHANGE, 0, -HALF_SPAN - 1, 5);
    send_beat(ACT_SET, -128, 127, 1);
    send_beat(ACT_CHANGE, 127, -128, 1);
    send_beat(ACT_READ, -HALF_SPAN, HALF_SPAN, 0);
    send_beat(ACT_READ, HALF_SPAN, -HALF_SPAN, 0);
    send_beat(ACT_SPARE, HALF_SPAN, HALF_SPAN, 255);
    send_beat(ACT_READ, -HALF_SPAN, -HALF_SPAN, -1);
    send_beat(ACT_READ, HALF_SPAN + 1, 0, 0);
  endtask

  // Run a few updates under each ceiling, extremes included; a cell set above
  // the ceiling drops to it on the next change, even a zero one.
  task automatic test_ceiling_settings();
    logic [7:0] levels [4];
    levels = '{8'd0, 8'd1, 8'd100, 8'd255};
    foreach (levels[i]) begin
      settle_pipe();
      write_ceiling(levels[i]);
      send_beat(ACT_SET, 3, -4, 200);
      send_beat(ACT_CHANGE, 3, -4, 0);
      send_beat(ACT_CHANGE, 3, -4, 255);
      send_beat(ACT_CHANGE, 3, -4, -1);
      send_beat(ACT_CHANGE, 3, -4, -256);
      send_beat(ACT_READ, 3, -4, 0);
    end
  endtask

  // Pick a coordinate: mostly the same or a nearby cell so updates pile up
  // back to back, some anywhere on the grid, a few across the whole type.
  function automatic int pick_coord(int last);
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 30)
      return last;
    if (r < 60) begin
      c = last + $urandom_range(0, 6) - 3;
      if (c > HALF_SPAN) c = HALF_SPAN;
      if (c < -HALF_SPAN) c = -HALF_SPAN;
      return c;
    end
    if (r < 90)
      return $urandom_range(0, 2 * HALF_SPAN) - HALF_SPAN;
    return $urandom_range(0, 255) - 128;
  endfunction

  // Random traffic in chunks, each under its own ceiling; the last chunks
  // run with no idling on either side.
  task automatic test_random_traffic(int count);
    int chunk;
    int r;
    int opnd;
    action_t act;
    for (int c = 0; c < 5; c++) begin
      settle_pipe();
      write_ceiling(c == 4 ? 8'd255 : 8'($urandom_range(0, 255)));
      idle_on = (c < 3);
      chunk = count / 5;
      for (int n = 0; n < chunk; n++) begin
        r = $urandom_range(0, 9);
        if (r < 3)
          act = ACT_SET;
        else if (r < 7)
          act = ACT_CHANGE;
        else if (r < 9)
          act = ACT_READ;
        else
          act = ACT_SPARE;
        // Keep half of the change deltas small so cells wander instead of pinning at a rail.
        if (act == ACT_CHANGE && $urandom_range(0, 1) == 0)
          opnd = $urandom_range(0, 40) - 20;
        else
          opnd = $urandom_range(0, 511) - 256;
        send_beat(act, pick_coord(last_x), pick_coord(last_y), opnd);
      end
    end
  endtask

  // Drive the result ready: it drops at random while idling, else stays high.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest owed cell.
  always @(posedge clk) begin
    cell_beat_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected result beat", cell_value, -1);
      end else begin
        want = pending_cells.pop_front();
        if (cell_value !== want.value)
          report_mismatch("cell_value", cell_value, want.value);
        if (in_bounds !== want.hit)
          report_mismatch("in_bounds", in_bounds, want.hit);
      end
    end
  end

  initial begin
    int guard;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 8'd0;
    in_valid       = 1'b0;
    action         = ACT_SET;
    x_coord        = 8'sd0;
    y_coord        = 8'sd0;
    operand        = 9'sd0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    last_x         = 0;
    last_y         = 0;
    ceiling        = CEILING_RST;
    foreach (grid_mem[i])
      grid_mem[i] = 8'd0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Hold off the first beats until the clearing pass is over: send_beat
    // waits on in_ready, so nothing to do here but start.
    test_cleared_after_reset();
    test_field_edges();
    test_ceiling_settings();
    test_random_traffic(850);

    // Drain with a limit, then let the pipe run dry.
    in_valid <= 1'b0;
    guard = 0;
    while (pending_cells.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_DEPTH) @(posedge clk);
    if (pending_cells.size() != 0)
      report_mismatch("results never returned", 0, pending_cells.size());

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing pass included.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
